[rtl/rcf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types, constants and the chunk header builder of the chunk framer.
// ----------------------------------------------------------------------------
package rcf_pkg;

	localparam int MaxBytes = 18;
	localparam int JobBits  = MaxBytes * 8;
	localparam int CntW     = $clog2(MaxBytes + 1);
	localparam int QDepth   = 2;
	localparam int QAw      = $clog2(QDepth);

	localparam logic        OpStart = 1'b0;
	localparam logic        OpData  = 1'b1;

	localparam logic [1:0]  FmtFull     = 2'd0;
	localparam logic [1:0]  FmtNoStream = 2'd1;
	localparam logic [1:0]  FmtTime     = 2'd2;
	localparam logic [1:0]  FmtCont     = 2'd3;

	localparam logic [23:0] TsMax        = 24'hFFFFFF;
	localparam logic [16:0] CsOneLimit   = 17'd64;
	localparam logic [16:0] CsTwoLimit   = 17'd320;
	localparam logic [16:0] CsOffset     = 17'd64;
	localparam logic [7:0]  CsThreeMark  = 8'h3f;
	localparam logic [23:0] ChunkReset   = 24'd128;

	localparam logic        RegChunkSize = 1'b0;

	// bytes are packed first byte in the lowest bits
	typedef struct packed {
		logic [JobBits-1:0] bytes;
		logic [CntW-1:0]    count;
		logic               done;
	} job_t;

	function automatic job_t build_header(
		input logic [1:0]  fmt,
		input logic [16:0] cs,
		input logic [31:0] ts,
		input logic [23:0] len,
		input logic [7:0]  typ,
		input logic [31:0] msid
	);
		job_t        j;
		logic [7:0]  top;
		logic [23:0] ts24;
		logic [16:0] v;
		logic [87:0] mh;
		logic [31:0] ext;
		logic [CntW-1:0] nb;
		logic [CntW-1:0] nm;
		logic        ext_en;
		top    = {fmt, 6'b0};
		ext_en = (ts >= {8'h00, TsMax});
		ts24   = ext_en ? TsMax : ts[23:0];
		v      = cs - CsOffset;
		j.bytes = '0;
		j.done  = 1'b0;
		if (cs < CsOneLimit) begin
			j.bytes[7:0] = top | {2'b00, cs[5:0]};
			nb = CntW'(1);
		end else if (cs < CsTwoLimit) begin
			j.bytes[15:0] = {v[7:0], top};
			nb = CntW'(2);
		end else begin
			j.bytes[23:0] = {v[15:8], v[7:0], top | CsThreeMark};
			nb = CntW'(3);
		end
		mh = {msid[31:24], msid[23:16], msid[15:8], msid[7:0], typ,
			len[7:0], len[15:8], len[23:16], ts24[7:0], ts24[15:8], ts24[23:16]};
		case (fmt)
			FmtFull: begin
				nm = CntW'(11);
			end
			FmtNoStream: begin
				nm = CntW'(7);
				mh = {32'b0, mh[55:0]};
			end
			FmtTime: begin
				nm = CntW'(3);
				mh = {64'b0, mh[23:0]};
			end
			default: begin
				nm = '0;
				mh = '0;
			end
		endcase
		j.bytes = j.bytes | (JobBits'(mh) << {nb, 3'b000});
		ext = {ts[7:0], ts[15:8], ts[23:16], ts[31:24]};
		if (ext_en) begin
			j.bytes = j.bytes | (JobBits'(ext) << {nb + nm, 3'b000});
		end
		j.count = nb + nm + (ext_en ? CntW'(4) : CntW'(0));
		return j;
	endfunction

endpackage
`default_nettype wire

[rtl/rcf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_front
// Accepts input items, tracks the open message and turns each item into a
// job of up to eighteen output bytes.
// ----------------------------------------------------------------------------
module rcf_front import rcf_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [1:0] msg_format, [18:2] chunk_stream, [50:19] time_value,
	// [74:51] msg_length, [82:75] type_id, [114:83] message_stream,
	// [122:115] data_byte, [127:123] zero
	input  wire logic [127:0] s_tdata,
	// [0] operation
	input  wire logic [0:0]   s_tuser,
	input  wire logic [23:0]  chunk_max,
	input  wire logic         q_full,
	output logic              push,
	output job_t              push_job
);

	logic [23:0] bytes_remaining_q;
	logic [23:0] chunk_left_q;
	logic [16:0] saved_stream_q;
	logic [31:0] saved_time_q;

	logic        accept;
	logic        op;
	logic [1:0]  msg_format;
	logic [16:0] chunk_stream;
	logic [31:0] time_value;
	logic [23:0] msg_length;
	logic [7:0]  type_id;
	logic [31:0] message_stream;
	logic [7:0]  data_byte;
	logic [23:0] eff_chunk;
	logic [23:0] br_next;
	logic [23:0] cl_next;
	job_t        hdr;
	job_t        cont;

	assign op             = s_tuser[0];
	assign msg_format     = s_tdata[1:0];
	assign chunk_stream   = s_tdata[18:2];
	assign time_value     = s_tdata[50:19];
	assign msg_length     = s_tdata[74:51];
	assign type_id        = s_tdata[82:75];
	assign message_stream = s_tdata[114:83];
	assign data_byte      = s_tdata[122:115];

	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign eff_chunk = (chunk_max == 24'd0) ? 24'd1 : chunk_max;
	assign br_next   = bytes_remaining_q - 24'd1;
	assign cl_next   = (chunk_left_q == 24'd0) ? 24'd0 : chunk_left_q - 24'd1;

	always_comb begin
		hdr  = build_header(msg_format, chunk_stream, time_value, msg_length,
			type_id, message_stream);
		cont = build_header(FmtCont, saved_stream_q, saved_time_q, 24'd0, 8'd0, 32'd0);
		push     = 1'b0;
		push_job = hdr;
		if (accept) begin
			if (op == OpStart) begin
				push          = 1'b1;
				push_job.done = (msg_length == 24'd0);
			end else if (bytes_remaining_q != 24'd0) begin
				push           = 1'b1;
				push_job.bytes = {{(JobBits-8){1'b0}}, data_byte};
				push_job.count = CntW'(1);
				push_job.done  = (br_next == 24'd0);
				// chunk boundary with bytes left: continuation header follows
				if (br_next != 24'd0 && cl_next == 24'd0) begin
					push_job.bytes = {cont.bytes[JobBits-9:0], data_byte};
					push_job.count = cont.count + CntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_remaining_q <= '0;
			chunk_left_q      <= '0;
			saved_stream_q    <= '0;
			saved_time_q      <= '0;
		end else if (accept) begin
			if (op == OpStart) begin
				saved_stream_q    <= chunk_stream;
				saved_time_q      <= time_value;
				bytes_remaining_q <= msg_length;
				chunk_left_q      <= eff_chunk;
			end else if (bytes_remaining_q != 24'd0) begin
				bytes_remaining_q <= br_next;
				if (br_next != 24'd0 && cl_next == 24'd0) begin
					chunk_left_q <= eff_chunk;
				end else begin
					chunk_left_q <= cl_next;
				end
			end
		end
	end

endmodule
`default_nettype wire

[rtl/rcf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_queue
// Short job queue between the front and the byte serializer.
// ----------------------------------------------------------------------------
module rcf_queue import rcf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output logic      empty,
	output logic      full
);

	job_t           mem_q [QDepth];
	logic [QAw-1:0] wr_ptr_q;
	logic [QAw-1:0] rd_ptr_q;
	logic [QAw:0]   count_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == (QAw+1)'(QDepth));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAw'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAw'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QAw+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QAw+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

[rtl/rcf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_back
// Walks the head job one byte a cycle into the output register while m_tready allows.
// ----------------------------------------------------------------------------
module rcf_back import rcf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire job_t       head,
	input  wire logic       q_empty,
	output logic            pop,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	// [7:0] out_byte
	output logic [7:0]      m_tdata,
	output logic            m_tlast,
	// [0] message_done
	output logic [0:0]      m_tuser
);

	logic [CntW-1:0] idx_q;
	logic            valid_q;
	logic [7:0]      byte_q;
	logic            last_q;
	logic            done_q;
	logic            load;
	logic            is_last;

	assign load    = !valid_q || m_tready;
	assign is_last = ((idx_q + CntW'(1)) == head.count);
	assign pop     = load && !q_empty && is_last;

	assign m_tvalid   = valid_q;
	assign m_tdata    = byte_q;
	assign m_tlast    = last_q;
	assign m_tuser[0] = done_q;

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			byte_q <= head.bytes[{idx_q, 3'b000} +: 8];
			last_q <= is_last;
			done_q <= is_last && head.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (!q_empty) begin
				idx_q <= is_last ? '0 : idx_q + CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

[rtl/rtmp_chunk_framer.sv]
`default_nettype none
// Path: an accepted item is queued, then its first byte loads into the m_tdata register.
// Throughput: one output byte per cycle from the serializer while m_tready is high; a
// payload item that yields one byte is taken every cycle while the queue is not full, a
// start item yields 1 to 18 header bytes and a chunk boundary adds 1 to 7 header bytes.
// Reset: queue and output empty, no open message, chunk limit back to 128.
// ----------------------------------------------------------------------------
// rtmp_chunk_framer
// Send-side chunk stream framer: headers, continuation headers and payload.
// ----------------------------------------------------------------------------
module rtmp_chunk_framer import rcf_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [1:0] msg_format, [18:2] chunk_stream, [50:19] time_value,
	// [74:51] msg_length, [82:75] type_id, [114:83] message_stream,
	// [122:115] data_byte, [127:123] zero
	input  wire logic [127:0] s_tdata,
	// [0] operation
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [7:0] out_byte
	output logic [7:0]        m_tdata,
	// last_of_run
	output logic              m_tlast,
	// [0] message_done
	output logic [0:0]        m_tuser,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [23:0] chunk_max_q;
	logic        q_full;
	logic        q_empty;
	logic        push;
	logic        pop;
	job_t        push_job;
	job_t        head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegChunkSize) ? {8'h00, chunk_max_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_max_q <= ChunkReset;
		end else if (psel && penable && pwrite && paddr[2] == RegChunkSize) begin
			chunk_max_q <= pwdata[23:0];
		end
	end

	rcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.chunk_max  (chunk_max_q),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	rcf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	rcf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTHESIS
	// message completion only ever lands on the final byte of a run
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("message_done without last_of_run");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("job queue popped while empty");

	a_job_count: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_job.count != '0 && push_job.count <= CntW'(MaxBytes)))
		else $error("job byte count out of range");

	// a finished job is dropped from the queue as its last byte loads
	a_pop_loads_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (m_tvalid && m_tlast))
		else $error("job popped without its last byte in the output register");
`endif

endmodule
`default_nettype wire

[verif/rtmp_chunk_framer_checker.sv]
// ----------------------------------------------------------------------------
// rtmp_chunk_framer_checker
// Watches the input, output and register ports of the chunk framer. It keeps
// its own copy of the framing state, predicts the framed bytes of every
// accepted item and compares each output byte against the oldest prediction.
// ----------------------------------------------------------------------------
module rtmp_chunk_framer_checker import rcf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [7:0]   m_tdata,
	input  logic         m_tlast,
	input  logic [0:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           errors,
	output int           pending,
	output int           bytes_checked,
	output int           messages_done
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ChunkSizeAddr = {RegChunkSize, 2'b00};

	// s_tdata layout, lowest field last
	typedef struct packed {
		logic [4:0]  zero_pad;
		logic [7:0]  data_byte;
		logic [31:0] message_stream;
		logic [7:0]  type_id;
		logic [23:0] msg_length;
		logic [31:0] time_value;
		logic [16:0] chunk_stream;
		logic [1:0]  msg_format;
	} item_fields_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} framed_byte_t;

	typedef logic [7:0] byte_run_t[$];

	framed_byte_t expected_bytes[$];

	logic [23:0] chunk_max;
	logic [23:0] msg_left;
	logic [23:0] chunk_room;
	logic [16:0] open_stream;
	logic [31:0] open_time;

	function automatic logic [23:0] chunk_limit();
		return (chunk_max == '0) ? 24'd1 : chunk_max;
	endfunction

	function automatic byte_run_t chunk_header(
		input logic [1:0]  fmt,
		input logic [16:0] cs,
		input logic [31:0] ts,
		input logic [23:0] len,
		input logic [7:0]  typ,
		input logic [31:0] msid
	);
		byte_run_t   run;
		logic [7:0]  top;
		logic [23:0] ts24;
		logic [16:0] v;
		logic        ext;
		top  = {fmt, 6'b0};
		ext  = (ts >= {8'h00, TsMax});
		ts24 = ext ? TsMax : ts[23:0];
		v    = cs - CsOffset;
		// basic header: one, two or three bytes by id range
		if (cs < CsOneLimit) begin
			run.push_back(top | cs[7:0]);
		end else if (cs < CsTwoLimit) begin
			run.push_back(top);
			run.push_back(v[7:0]);
		end else begin
			run.push_back(top | CsThreeMark);
			run.push_back(v[7:0]);
			run.push_back(v[15:8]);
		end
		if (fmt != FmtCont) begin
			run.push_back(ts24[23:16]);
			run.push_back(ts24[15:8]);
			run.push_back(ts24[7:0]);
		end
		if (fmt == FmtFull || fmt == FmtNoStream) begin
			run.push_back(len[23:16]);
			run.push_back(len[15:8]);
			run.push_back(len[7:0]);
			run.push_back(typ);
		end
		// stream id goes out little-endian
		if (fmt == FmtFull) begin
			run.push_back(msid[7:0]);
			run.push_back(msid[15:8]);
			run.push_back(msid[23:16]);
			run.push_back(msid[31:24]);
		end
		if (ext) begin
			run.push_back(ts[31:24]);
			run.push_back(ts[23:16]);
			run.push_back(ts[15:8]);
			run.push_back(ts[7:0]);
		end
		return run;
	endfunction

	// tlast marks the final byte of the run; done can only land there too
	task automatic queue_run(input byte_run_t run, input logic done);
		framed_byte_t entry;
		foreach (run[i]) begin
			entry.data = run[i];
			entry.last = (i == run.size() - 1);
			entry.done = done && (i == run.size() - 1);
			expected_bytes.push_back(entry);
		end
	endtask

	task automatic predict_framing(input logic [0:0] op, input item_fields_t f);
		byte_run_t run;
		byte_run_t cont;
		if (op == OpStart) begin
			open_stream = f.chunk_stream;
			open_time   = f.time_value;
			msg_left    = f.msg_length;
			chunk_room  = chunk_limit();
			queue_run(chunk_header(f.msg_format, f.chunk_stream, f.time_value,
				f.msg_length, f.type_id, f.message_stream), f.msg_length == '0);
		end else if (msg_left != '0) begin
			msg_left = msg_left - 24'd1;
			if (chunk_room != '0)
				chunk_room = chunk_room - 24'd1;
			run.push_back(f.data_byte);
			if (msg_left == '0) begin
				queue_run(run, 1'b1);
			end else begin
				if (chunk_room == '0) begin
					cont = chunk_header(FmtCont, open_stream, open_time, '0, '0, '0);
					foreach (cont[i])
						run.push_back(cont[i]);
					chunk_room = chunk_limit();
				end
				queue_run(run, 1'b0);
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns: framer mismatch: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		framed_byte_t want;
		item_fields_t fields;
		if (!arst_n) begin
			expected_bytes.delete();
			chunk_max     = ChunkReset;
			msg_left      = '0;
			chunk_room    = '0;
			open_stream   = '0;
			open_time     = '0;
			errors        = 0;
			pending       = 0;
			bytes_checked = 0;
			messages_done = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ChunkSizeAddr)
				chunk_max = pwdata[23:0];
			if (m_tvalid && m_tready) begin
				bytes_checked++;
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %02h with nothing expected", m_tdata));
				end else begin
					want = expected_bytes.pop_front();
					if (m_tdata != want.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							m_tdata, want.data));
					if (m_tlast != want.last)
						report_mismatch($sformatf("last_of_run %0b, expected %0b on byte %02h",
							m_tlast, want.last, want.data));
					if (m_tuser[0] != want.done)
						report_mismatch($sformatf("message_done %0b, expected %0b on byte %02h",
							m_tuser[0], want.done, want.data));
					if (want.done)
						messages_done++;
				end
			end
			if (s_tvalid && s_tready) begin
				fields = s_tdata;
				predict_framing(s_tuser, fields);
			end
			pending = expected_bytes.size();
		end
	end

endmodule

[verif/rtmp_chunk_framer_tb.sv]
// ----------------------------------------------------------------------------
// rtmp_chunk_framer_tb
// Drives header and payload items into the chunk framer under several idle
// and stall mixes and chunk sizes; the checker predicts and compares bytes.
// ----------------------------------------------------------------------------
module rtmp_chunk_framer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcf_pkg::*;

	localparam int         CycleLimit    = 500000;
	localparam int         SettleCycles  = 16;
	localparam int         PhaseItems    = 72;
	localparam int         HoldCycles    = 300;
	localparam logic [2:0] ChunkSizeAddr = {RegChunkSize, 2'b00};

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic [127:0] s_tdata  = '0;
	logic [0:0]   s_tuser  = OpData;
	logic         m_tready = 1'b0;
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [2:0]   paddr    = '0;
	logic [31:0]  pwdata   = '0;
	logic         s_tready;
	logic         m_tvalid;
	logic [7:0]   m_tdata;
	logic         m_tlast;
	logic [0:0]   m_tuser;
	logic [31:0]  prdata;
	logic         pready;

	int   send_idle    = 0;
	int   stall_pct    = 0;
	logic rx_hold      = 1'b0;
	int   cycles       = 0;
	int   items_sent   = 0;
	int   useful_items = 0;
	int   errors;
	int   pending;
	int   bytes_checked;
	int   messages_done;

	rtmp_chunk_framer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	rtmp_chunk_framer_checker framing_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.errors        (errors),
		.pending       (pending),
		.bytes_checked (bytes_checked),
		.messages_done (messages_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("timeout after %0d cycles, %0d bytes still expected", cycles, pending);
			$display("rtmp_chunk_framer_tb NOT OK");
			$finish;
		end
	end

	// valid stays high across back-to-back items; it only drops in an idle gap or a drain
	task automatic send_item(input logic [0:0] op, input logic [1:0] fmt,
		input logic [16:0] cs, input logic [31:0] ts, input logic [23:0] len,
		input logic [7:0] typ, input logic [31:0] msid, input logic [7:0] db);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b0, db, msid, typ, len, ts, cs, fmt};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_start(input logic [1:0] fmt, input logic [16:0] cs,
		input logic [31:0] ts, input logic [23:0] len, input logic [7:0] typ,
		input logic [31:0] msid);
		send_item(OpStart, fmt, cs, ts, len, typ, msid, 8'($urandom_range(255)));
	endtask

	// header fields of a payload item are don't-care, so they get noise
	task automatic send_byte(input logic [7:0] db);
		send_item(OpData, 2'($urandom_range(3)), 17'($urandom_range(17'h1FFFF)),
			$urandom, 24'($urandom_range(24'hFFFFFF)), 8'($urandom_range(255)),
			$urandom, db);
	endtask

	task automatic drain_block();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// dropped payload items leave no trace in the checker, give them time
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_chunk_limit(input logic [31:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ChunkSizeAddr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [16:0] pick_stream();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 17'($urandom_range(1));
		else if (r < 30)
			return 17'($urandom_range(63, 2));
		else if (r < 55)
			return 17'($urandom_range(319, 64));
		else if (r < 88)
			return 17'($urandom_range(65599, 320));
		else
			return 17'($urandom_range(17'h1FFFF, 65600));
	endfunction

	function automatic logic [31:0] pick_time();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return 32'($urandom_range(32'hFFFF));
		else if (r < 65)
			return 32'($urandom_range(32'h0100000F, 32'h00FFFFF0));
		else
			return $urandom;
	endfunction

	// mostly complete messages; some are cut short by the next start, some
	// claim a huge length, a few are followed by stray payload items
	task automatic random_message();
		logic [23:0] len;
		int          nbytes;
		int          r;
		r = $urandom_range(99);
		if (r < 80)
			len = 24'($urandom_range(20));
		else if (r < 95)
			len = 24'($urandom_range(70, 21));
		else
			len = 24'($urandom_range(24'hFFFFFF));
		nbytes = int'(len);
		if (len > 24'd70 || $urandom_range(99) < 8)
			nbytes = $urandom_range((len > 24'd8) ? 8 : int'(len));
		send_start(2'($urandom_range(3)), pick_stream(), pick_time(), len,
			8'($urandom_range(255)), $urandom);
		useful_items++;
		repeat (nbytes) begin
			send_byte(8'($urandom_range(255)));
			useful_items++;
		end
		if (nbytes == int'(len) && $urandom_range(99) < 8)
			repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
	endtask

	task automatic run_phase(input int idle, input int stall, input logic [31:0] chunk);
		int target;
		write_chunk_limit(chunk);
		send_idle = idle;
		stall_pct <= stall;
		target = useful_items + PhaseItems;
		while (useful_items < target)
			random_message();
		drain_block();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header shapes at the reset chunk size
		send_byte(8'hA5);
		send_start(FmtFull, 17'd2, 32'h0, 24'h0, 8'h00, 32'h0);
		send_start(FmtNoStream, 17'd63, 32'h00FFFFFE, 24'h0, 8'hFF, 32'hFFFFFFFF);
		send_start(FmtTime, 17'd64, 32'h00FFFFFF, 24'h0, 8'h5A, 32'h0);
		send_start(FmtCont, 17'd319, 32'hFFFFFFFF, 24'h0, 8'h00, 32'h0);
		send_start(FmtFull, 17'd320, 32'h12345678, 24'd2, 8'h14, 32'hFFFFFFFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_start(FmtFull, 17'd65599, 32'h01000000, 24'h0, 8'h12, 32'h04030201);
		send_start(FmtNoStream, 17'd0, 32'd5, 24'h0, 8'h01, 32'h0);
		send_start(FmtTime, 17'd1, 32'd6, 24'h0, 8'h02, 32'h0);
		send_start(FmtFull, 17'h1FFFF, 32'd7, 24'h0, 8'h03, 32'h1);
		// huge message cut short by a new start
		send_start(FmtFull, 17'd100, 32'd7, 24'hFFFFFF, 8'h09, 32'h1);
		send_byte(8'h11);
		send_byte(8'h22);
		send_start(FmtNoStream, 17'd5, 32'd9, 24'd1, 8'h08, 32'h0);
		send_byte(8'h3C);
		drain_block();

		// zero chunk size acts as one byte per chunk, with extended timestamps
		write_chunk_limit(32'h0);
		send_start(FmtNoStream, 17'd70, 32'hFEDCBA98, 24'd2, 8'h07, 32'h0);
		send_byte(8'h81);
		send_byte(8'h82);
		drain_block();

		// chunk size change in the middle of an open message
		write_chunk_limit(32'd2);
		send_start(FmtTime, 17'd400, 32'h10, 24'd4, 8'h00, 32'h0);
		send_byte(8'h91);
		drain_block();
		write_chunk_limit(32'd3);
		send_byte(8'h92);
		send_byte(8'h93);
		send_byte(8'h94);
		drain_block();

		run_phase(0, 0, 32'd1);
		run_phase(54, 0, {8'($urandom_range(255)), 24'($urandom_range(8, 2))});
		run_phase(0, 54, 32'h00FFFFFF);
		run_phase(29, 29, {8'($urandom_range(255)), 24'($urandom_range(16, 4))});

		// long receiver hold while the sender keeps pushing payload
		send_idle = 0;
		stall_pct <= 0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		send_start(FmtFull, pick_stream(), pick_time(), 24'd30, 8'h09, $urandom);
		repeat (30) send_byte(8'($urandom_range(255)));
		drain_block();

		$display("%0d items sent (%0d framed), every header format, stream id range and",
			items_sent, useful_items + 55);
		$display("chunk sizes 0, 1, small and max; %0d bytes checked, %0d messages closed",
			bytes_checked, messages_done);
		if (errors == 0) begin
			$display("rtmp_chunk_framer_tb OK");
		end else begin
			$display("rtmp_chunk_framer_tb NOT OK");
		end
		$finish;
	end

endmodule
